FILE: sv/pcx_pkg.sv
package pcx_pkg;

    // defaults for the size limits of the top level
    localparam int unsigned DEF_MAX_WIDTH  = 4096;
    localparam int unsigned DEF_MAX_HEIGHT = 4096;
    localparam int unsigned DEF_MAX_PLANES = 4;

    // field and register widths
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned ADDR_W      = 26;
    localparam int unsigned STAT_W      = 2;
    localparam int unsigned RUN_W       = 6;
    localparam int unsigned DIM_W       = 13;
    localparam int unsigned PLANE_CFG_W = 3;
    localparam int unsigned BPP_W       = 4;
    localparam int unsigned CFG_W       = 13;
    localparam int unsigned CFG_IDX_W   = 3;

    // run marker: both top bits set, low six bits hold the repeat count
    localparam logic [BYTE_W-1:0] RUN_MARK_BITS  = 8'hC0;
    localparam logic [BYTE_W-1:0] RUN_COUNT_BITS = 8'h3F;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_PIXEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_LINE_BYTES = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_BUSY = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DONE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FAIL = 2'd2;

    // depth of the job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_RUN = 2'd0,
        KIND_NOP = 2'd1,
        KIND_EOS = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [RUN_W-1:0]  count;
        logic [BYTE_W-1:0] value;
    } t_job;

    typedef struct packed {
        logic [DIM_W-1:0]       image_width;
        logic [DIM_W-1:0]       image_height;
        logic [PLANE_CFG_W-1:0] plane_count;
        logic [BPP_W-1:0]       bits_per_plane_pixel;
        logic [DIM_W-1:0]       plane_line_bytes;
    } t_cfg;

endpackage

FILE: sv/pcx_front.sv
module pcx_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pcx_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_end_of_stream,
    output logic                          o_job_valid,
    output pcx_pkg::t_job                 o_job,
    input  logic                          i_job_ready
);

    logic                         r_f_valid;
    pcx_pkg::t_job                r_f_job;
    logic                         r_armed;
    logic [pcx_pkg::RUN_W-1:0]    r_pending;

    pcx_pkg::t_job                n_job;
    logic                         n_armed;
    logic [pcx_pkg::RUN_W-1:0]    n_pending;
    logic                         accept;
    logic                         move;

    assign move        = r_f_valid && i_job_ready;
    assign o_stall     = r_f_valid && !i_job_ready;
    assign accept      = i_valid && !o_stall;
    assign o_job_valid = r_f_valid;
    assign o_job       = r_f_job;

    // classify the byte: end mark, run byte after a marker, marker, literal
    always_comb begin
        n_job.kind  = pcx_pkg::KIND_NOP;
        n_job.count = '0;
        n_job.value = i_data_byte;
        n_armed     = r_armed;
        n_pending   = r_pending;
        if (i_end_of_stream) begin
            n_job.kind = pcx_pkg::KIND_EOS;
        end else if (r_armed) begin
            n_armed     = 1'b0;
            n_pending   = '0;
            n_job.count = r_pending;
            n_job.kind  = (r_pending == '0) ? pcx_pkg::KIND_NOP : pcx_pkg::KIND_RUN;
        end else if ((i_data_byte & pcx_pkg::RUN_MARK_BITS) == pcx_pkg::RUN_MARK_BITS) begin
            n_armed   = 1'b1;
            n_pending = pcx_pkg::RUN_W'(i_data_byte & pcx_pkg::RUN_COUNT_BITS);
        end else begin
            n_job.kind  = pcx_pkg::KIND_RUN;
            n_job.count = pcx_pkg::RUN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_armed   <= 1'b0;
            r_pending <= '0;
        end else if (accept) begin
            r_f_valid <= 1'b1;
            r_armed   <= n_armed;
            r_pending <= n_pending;
        end else if (move) begin
            r_f_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_job <= n_job;
        end
    end

endmodule

FILE: sv/pcx_queue.sv
module pcx_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  pcx_pkg::t_job i_push,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output pcx_pkg::t_job o_pop,
    input  logic          i_pop
);

    localparam int unsigned DEPTH = pcx_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pcx_pkg::t_job     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;

    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop        = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr + 1'b1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd + 1'b1);
            end
            if (push && !pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (pop && !push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push;
        end
    end

endmodule

FILE: sv/pcx_back.sv
module pcx_back #(
    parameter int unsigned MAX_WIDTH  = pcx_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = pcx_pkg::DEF_MAX_HEIGHT,
    parameter int unsigned MAX_PLANES = pcx_pkg::DEF_MAX_PLANES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcx_pkg::t_cfg                 i_cfg,
    input  logic                          i_job_valid,
    input  pcx_pkg::t_job                 i_job,
    output logic                          o_job_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pcx_pkg::BYTE_W-1:0]    o_pixel_byte,
    output logic [pcx_pkg::ADDR_W-1:0]    o_dest_addr,
    output logic                          o_has_data,
    output logic                          o_run_last,
    output logic [pcx_pkg::STAT_W-1:0]    o_status
);

    localparam int unsigned BPP_MAX = (2 ** pcx_pkg::BPP_W) - 1;
    localparam int unsigned LEN_W   = $clog2(MAX_WIDTH + 1);
    localparam int unsigned LP_W    = $clog2(MAX_WIDTH * MAX_PLANES + 1);
    localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned P_W     = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int unsigned PL_W    = $clog2(MAX_PLANES + 1);
    localparam int unsigned WB_W    = $clog2(MAX_WIDTH * BPP_MAX + 1);
    localparam int unsigned WBP_W   = $clog2(MAX_WIDTH * BPP_MAX * MAX_PLANES + 1);
    localparam int unsigned RB_W    = WBP_W - 3;
    localparam int unsigned AW      = pcx_pkg::ADDR_W;
    localparam int unsigned BW      = pcx_pkg::BYTE_W;
    localparam int unsigned SW      = pcx_pkg::STAT_W;
    localparam int unsigned CW      = pcx_pkg::RUN_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // multiply by a plane count of one to four with shifts and one add
    function automatic logic [31:0] times_planes(input logic [31:0] v,
                                                 input logic [PL_W-1:0] n);
        logic [31:0] res;
        if (32'(n) == 32'd1) begin
            res = v;
        end else if (32'(n) == 32'd2) begin
            res = v << 1;
        end else if (32'(n) == 32'd3) begin
            res = v + (v << 1);
        end else begin
            res = v << 2;
        end
        return res;
    endfunction

    // geometry, first stage
    logic [LEN_W-1:0]      g_w;
    logic [LEN_W-1:0]      g_len;
    logic [ROW_W-1:0]      g_h;
    logic [PL_W-1:0]       g_planes;
    logic [WB_W-1:0]       g_wb;
    logic [WBP_W-1:0]      g_wbp;

    logic [LEN_W-1:0]      r_len;
    logic [PL_W-1:0]       r_planes;
    logic [ROW_W-1:0]      r_h;
    logic [LP_W-1:0]       r_line_len;
    logic [LP_W-1:0]       r_len_mul [MAX_PLANES];
    logic [RB_W-1:0]       r_row_bytes;
    logic [AW-1:0]         r_row_base;
    logic [ROW_W+RB_W-1:0] row_prod;

    // scanline position and its split into plane and column
    logic [LP_W-1:0]       r_lp;
    logic [ROW_W-1:0]      r_row;
    logic [LEN_W-1:0]      r_x;
    logic [P_W-1:0]        r_p;
    logic [LP_W-1:0]       r_xoff;
    logic [LEN_W-1:0]      d_x;
    logic [P_W-1:0]        d_p;
    logic [LP_W-1:0]       d_xoff;

    t_state                r_state;
    logic                  r_finished;
    logic                  r_failed;
    logic [CW-1:0]         r_cnt;
    logic [BW-1:0]         r_val;
    logic [SW-1:0]         r_job_stat;
    logic                  r_hold_v;
    logic [BW-1:0]         r_hold_byte;
    logic [AW-1:0]         r_hold_addr;
    logic                  r_o_valid;
    logic [BW-1:0]         r_o_byte;
    logic [AW-1:0]         r_o_addr;
    logic                  r_o_has;
    logic                  r_o_last;
    logic [SW-1:0]         r_o_stat;

    t_state                n_state;
    logic                  n_finished;
    logic                  n_failed;
    logic [CW-1:0]         n_cnt;
    logic [BW-1:0]         n_val;
    logic [SW-1:0]         n_job_stat;
    logic                  n_hold_v;
    logic [BW-1:0]         n_hold_byte;
    logic [AW-1:0]         n_hold_addr;
    logic                  n_o_valid;
    logic [BW-1:0]         n_o_byte;
    logic [AW-1:0]         n_o_addr;
    logic                  n_o_has;
    logic                  n_o_last;
    logic [SW-1:0]         n_o_stat;
    logic [LP_W-1:0]       n_lp;
    logic [ROW_W-1:0]      n_row;
    logic [LEN_W-1:0]      n_x;
    logic [P_W-1:0]        n_p;
    logic [LP_W-1:0]       n_xoff;

    logic                  out_free;
    logic                  take;
    logic                  run_ok;
    logic                  step;
    logic [CW-1:0]         st_cnt;
    logic [BW-1:0]         st_val;
    logic [SW-1:0]         st_stat;
    logic [SW-1:0]         cur_stat;
    logic                  start_fin;
    logic                  iter;
    logic [LP_W-1:0]       off;
    logic                  emit;
    logic [LP_W-1:0]       lp_next;
    logic                  wrap;
    logic                  done;
    logic [AW-1:0]         addr;

    // clamp the registers and derive the scanline geometry
    always_comb begin
        if (32'(i_cfg.image_width) > MAX_WIDTH) begin
            g_w = LEN_W'(MAX_WIDTH);
        end else begin
            g_w = LEN_W'(i_cfg.image_width);
        end
        if (i_cfg.plane_line_bytes == '0) begin
            g_len = LEN_W'(1);
        end else if (32'(i_cfg.plane_line_bytes) > MAX_WIDTH) begin
            g_len = LEN_W'(MAX_WIDTH);
        end else begin
            g_len = LEN_W'(i_cfg.plane_line_bytes);
        end
        if (i_cfg.image_height == '0) begin
            g_h = ROW_W'(1);
        end else if (32'(i_cfg.image_height) > MAX_HEIGHT) begin
            g_h = ROW_W'(MAX_HEIGHT);
        end else begin
            g_h = ROW_W'(i_cfg.image_height);
        end
        if (i_cfg.plane_count == '0) begin
            g_planes = PL_W'(1);
        end else if (32'(i_cfg.plane_count) > MAX_PLANES) begin
            g_planes = PL_W'(MAX_PLANES);
        end else begin
            g_planes = PL_W'(i_cfg.plane_count);
        end
        g_wb  = WB_W'(g_w) * WB_W'(i_cfg.bits_per_plane_pixel);
        g_wbp = WBP_W'(times_planes(32'(g_wb), g_planes));
    end

    always_ff @(posedge i_clk) begin
        r_len       <= g_len;
        r_planes    <= g_planes;
        r_h         <= g_h;
        r_line_len  <= LP_W'(times_planes(32'(g_len), g_planes));
        r_row_bytes <= g_wbp[WBP_W-1:3];
        for (int k = 0; k < MAX_PLANES; k++) begin
            r_len_mul[k] <= LP_W'(32'(g_len) * 32'(k));
        end
        r_row_base  <= AW'(row_prod);
    end

    assign row_prod = (ROW_W+RB_W)'(r_row) * (ROW_W+RB_W)'(r_row_bytes);

    // plane and column of the current position, rebuilt whenever no run byte is stepped
    always_comb begin
        d_p = '0;
        for (int k = 1; k < MAX_PLANES; k++) begin
            if (r_lp >= r_len_mul[k]) begin
                d_p = P_W'(k);
            end
        end
        d_x    = LEN_W'(r_lp - r_len_mul[d_p]);
        d_xoff = LP_W'(times_planes(32'(d_x), r_planes));
    end

    assign out_free  = !r_o_valid || !i_stall;
    assign run_ok    = !r_finished && !r_failed;
    assign take      = (r_state == S_IDLE) && i_job_valid && out_free;
    assign step      = (take && (i_job.kind == pcx_pkg::KIND_RUN) && run_ok)
                     || ((r_state == S_RUN) && out_free);
    assign o_job_pop = take;

    assign cur_stat  = r_finished ? pcx_pkg::STAT_DONE
                     : (r_failed ? pcx_pkg::STAT_FAIL : pcx_pkg::STAT_BUSY);
    assign start_fin = ((LP_W+1)'(r_lp) + (LP_W+1)'(i_job.count) >= (LP_W+1)'(r_line_len))
                     && ((ROW_W+1)'(r_row) + (ROW_W+1)'(1) >= (ROW_W+1)'(r_h));
    assign st_cnt    = (r_state == S_RUN) ? r_cnt : i_job.count;
    assign st_val    = (r_state == S_RUN) ? r_val : i_job.value;
    assign st_stat   = (r_state == S_RUN) ? r_job_stat
                     : (start_fin ? pcx_pkg::STAT_DONE : pcx_pkg::STAT_BUSY);

    assign iter    = r_lp < r_line_len;
    assign off     = r_xoff + LP_W'(r_p);
    assign emit    = iter && (32'(off) < 32'(r_row_bytes));
    assign lp_next = iter ? LP_W'(r_lp + 1'b1) : r_lp;
    assign wrap    = lp_next >= r_line_len;
    assign done    = (st_cnt == CW'(1)) || wrap;
    assign addr    = r_row_base + AW'(off);

    always_comb begin
        n_state     = r_state;
        n_finished  = r_finished;
        n_failed    = r_failed;
        n_cnt       = r_cnt;
        n_val       = r_val;
        n_job_stat  = r_job_stat;
        n_hold_v    = r_hold_v;
        n_hold_byte = r_hold_byte;
        n_hold_addr = r_hold_addr;
        n_o_valid   = r_o_valid && i_stall;
        n_o_byte    = r_o_byte;
        n_o_addr    = r_o_addr;
        n_o_has     = r_o_has;
        n_o_last    = r_o_last;
        n_o_stat    = r_o_stat;
        n_lp        = r_lp;
        n_row       = r_row;
        n_x         = d_x;
        n_p         = d_p;
        n_xoff      = d_xoff;

        case (r_state)
            S_IDLE: begin
                if (take && !step) begin
                    // marker, end mark or anything after the image is over or has failed
                    n_o_valid = 1'b1;
                    n_o_byte  = '0;
                    n_o_addr  = '0;
                    n_o_has   = 1'b0;
                    n_o_last  = 1'b1;
                    n_o_stat  = cur_stat;
                    if (i_job.kind == pcx_pkg::KIND_EOS && !r_finished) begin
                        n_failed = 1'b1;
                        n_o_stat = pcx_pkg::STAT_FAIL;
                    end
                end
            end
            S_RUN: begin
            end
            S_FIN: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_byte  = r_hold_v ? r_hold_byte : '0;
                    n_o_addr  = r_hold_v ? r_hold_addr : '0;
                    n_o_has   = r_hold_v;
                    n_o_last  = 1'b1;
                    n_o_stat  = r_job_stat;
                    n_hold_v  = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (step) begin
            // one byte of the run; the previous kept byte goes out once a later one exists
            if (emit) begin
                if (r_hold_v) begin
                    n_o_valid = 1'b1;
                    n_o_byte  = r_hold_byte;
                    n_o_addr  = r_hold_addr;
                    n_o_has   = 1'b1;
                    n_o_last  = 1'b0;
                    n_o_stat  = st_stat;
                end
                n_hold_v    = 1'b1;
                n_hold_byte = st_val;
                n_hold_addr = addr;
            end
            if (wrap) begin
                n_lp   = '0;
                n_row  = ROW_W'(r_row + 1'b1);
                n_x    = '0;
                n_p    = '0;
                n_xoff = '0;
                if (st_stat == pcx_pkg::STAT_DONE) begin
                    n_finished = 1'b1;
                end
            end else begin
                n_lp = lp_next;
                if (iter) begin
                    if (LEN_W'(r_x + 1'b1) == r_len) begin
                        n_x    = '0;
                        n_xoff = '0;
                        n_p    = P_W'(r_p + 1'b1);
                    end else begin
                        n_x    = LEN_W'(r_x + 1'b1);
                        n_xoff = LP_W'(r_xoff + LP_W'(r_planes));
                        n_p    = r_p;
                    end
                end else begin
                    n_x    = r_x;
                    n_p    = r_p;
                    n_xoff = r_xoff;
                end
            end
            n_cnt      = CW'(st_cnt - 1'b1);
            n_val      = st_val;
            n_job_stat = st_stat;
            n_state    = done ? S_FIN : S_RUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_finished <= 1'b0;
            r_failed   <= 1'b0;
            r_hold_v   <= 1'b0;
            r_o_valid  <= 1'b0;
            r_lp       <= '0;
            r_row      <= '0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_finished <= n_finished;
            r_failed   <= n_failed;
            r_hold_v   <= n_hold_v;
            r_o_valid  <= n_o_valid;
            r_lp       <= n_lp;
            r_row      <= n_row;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val       <= n_val;
        r_job_stat  <= n_job_stat;
        r_hold_byte <= n_hold_byte;
        r_hold_addr <= n_hold_addr;
        r_o_byte    <= n_o_byte;
        r_o_addr    <= n_o_addr;
        r_o_has     <= n_o_has;
        r_o_last    <= n_o_last;
        r_o_stat    <= n_o_stat;
        r_x         <= n_x;
        r_p         <= n_p;
        r_xoff      <= n_xoff;
    end

    assign o_valid      = r_o_valid;
    assign o_pixel_byte = r_o_byte;
    assign o_dest_addr  = r_o_addr;
    assign o_has_data   = r_o_has;
    assign o_run_last   = r_o_last;
    assign o_status     = r_o_stat;

endmodule

FILE: sv/pcx_rle_planar_decoder.sv
// pcx run-length pixel decoder with plane interleave. one compressed byte
// enters per transaction; a byte with both top bits set is a run marker whose
// low six bits repeat the next byte, any other byte is a literal. each decoded
// byte that lands inside the visible row leaves as its own transaction with
// its address in the interleaved image (row * row_bytes + column * planes +
// plane); padding and bytes past the end of a scanline are dropped. every
// input gives at least one output transaction, the last one flagged with
// run_last, and all of them carry the status after that input. a marker, an
// end mark or any byte after the image is over or has failed gives only that
// flagged transaction. a run (a literal is a run of one) is cut short at the
// end of a scanline; the run unit produces one byte per cycle while the
// output is not stalled, and closes the run in its final state with the
// flagged last transaction. a two-entry queue sits between the byte
// classifier and the run unit, so input keeps flowing while a run is worked
// off, until the queue fills. configuration writes pass through registered
// geometry and do not restart decoding.
module pcx_rle_planar_decoder #(
    parameter int unsigned MAX_WIDTH  = pcx_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = pcx_pkg::DEF_MAX_HEIGHT,
    parameter int unsigned MAX_PLANES = pcx_pkg::DEF_MAX_PLANES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [pcx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pcx_pkg::CFG_W-1:0]       i_cfg_data,
    // compressed byte channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [pcx_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                            i_end_of_stream,
    // decoded byte channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [pcx_pkg::BYTE_W-1:0]      o_pixel_byte,
    output logic [pcx_pkg::ADDR_W-1:0]      o_dest_addr,
    output logic                            o_has_data,
    output logic                            o_run_last,
    output logic [pcx_pkg::STAT_W-1:0]      o_status
);

    pcx_pkg::t_cfg r_cfg;

    // classifier to queue
    logic          front_valid;
    pcx_pkg::t_job front_job;
    logic          queue_ready;
    // queue to run unit
    logic          queue_valid;
    pcx_pkg::t_job queue_job;
    logic          queue_pop;

    // configuration registers; unused indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width          <= pcx_pkg::DIM_W'(1);
            r_cfg.image_height         <= pcx_pkg::DIM_W'(1);
            r_cfg.plane_count          <= pcx_pkg::PLANE_CFG_W'(1);
            r_cfg.bits_per_plane_pixel <= pcx_pkg::BPP_W'(8);
            r_cfg.plane_line_bytes     <= pcx_pkg::DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcx_pkg::CFG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= i_cfg_data[pcx_pkg::DIM_W-1:0];
                end
                pcx_pkg::CFG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= i_cfg_data[pcx_pkg::DIM_W-1:0];
                end
                pcx_pkg::CFG_PLANE_COUNT: begin
                    r_cfg.plane_count <= i_cfg_data[pcx_pkg::PLANE_CFG_W-1:0];
                end
                pcx_pkg::CFG_BITS_PER_PIXEL: begin
                    r_cfg.bits_per_plane_pixel <= i_cfg_data[pcx_pkg::BPP_W-1:0];
                end
                pcx_pkg::CFG_PLANE_LINE_BYTES: begin
                    r_cfg.plane_line_bytes <= i_cfg_data[pcx_pkg::DIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // front: takes bytes, tracks the marker, turns each byte into a job
    pcx_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_job_valid     (front_valid),
        .o_job           (front_job),
        .i_job_ready     (queue_ready)
    );

    // short job queue decoupling the classifier from the run unit
    pcx_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push       (front_job),
        .o_push_ready (queue_ready),
        .o_pop_valid  (queue_valid),
        .o_pop        (queue_job),
        .i_pop        (queue_pop)
    );

    // back: walks the scanline, one decoded byte per cycle while the output is not stalled
    pcx_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_PLANES (MAX_PLANES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_job_valid  (queue_valid),
        .i_job        (queue_job),
        .o_job_pop    (queue_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_byte (o_pixel_byte),
        .o_dest_addr  (o_dest_addr),
        .o_has_data   (o_has_data),
        .o_run_last   (o_run_last),
        .o_status     (o_status)
    );

endmodule
